FILE: hw/rtl/prht_pkg.sv
// Shared constants, codes and control types of the prime remainder hash table.
package prht_pkg;

   // Table geometry.
   localparam int TABLE_PRIME    = 19;
   localparam int OVERFLOW_SLOTS = 4;
   localparam int KEY_BITS       = 16;
   localparam int TOTAL_SLOTS    = TABLE_PRIME + OVERFLOW_SLOTS;
   localparam int SLOT_W         = $clog2(TOTAL_SLOTS);
   localparam int PROBE_W        = $clog2(OVERFLOW_SLOTS + 2);

   // Fixed field widths of the channels.
   localparam int KEY_W    = 16;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int SLOT_F_W = 5;
   localparam int HASH_F_W = 5;
   localparam int PROBES_W = 3;

   // Only the low KEY_BITS bits of a key take part in hashing and matching.
   localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KEY_BITS) - 64'd1);

   // Reciprocal of the prime scaled by 2^KEY_W; the quotient estimate it gives
   // is at most one below the true quotient.
   localparam logic [KEY_W-1:0] HASH_RECIP = KEY_W'((64'd1 << KEY_W) / TABLE_PRIME);

   // Request operations.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic hash_mul;
      logic hash_red;
      logic probe;
      logic load_rsp;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic probe_done;
      logic rsp_free;
   } dp_status_type;

endpackage

FILE: hw/rtl/prht_if.sv
// Request and response channel interfaces of the prime remainder hash table.
interface prht_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [prht_pkg::KEY_W-1:0]  key;
   logic [prht_pkg::DATA_W-1:0] data_in;

   modport source (output valid, output op, output key, output data_in, input ready);
   modport sink   (input valid, input op, input key, input data_in, output ready);
endinterface

interface prht_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [prht_pkg::STATUS_W-1:0] status;
   logic [prht_pkg::DATA_W-1:0]   data_out;
   logic [prht_pkg::SLOT_F_W-1:0] slot;
   logic [prht_pkg::HASH_F_W-1:0] hash_value;
   logic [prht_pkg::PROBES_W-1:0] probes;
   logic                          collision;

   modport source (output valid, output status, output data_out, output slot,
                   output hash_value, output probes, output collision, input ready);
   modport sink   (input valid, input status, input data_out, input slot,
                   input hash_value, input probes, input collision, output ready);
endinterface

FILE: hw/rtl/prht_ctrl.sv
// Controller state machine that sequences hashing, probing and result delivery.
module prht_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  prht_pkg::dp_status_type status,
   output prht_pkg::ctrl_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_HASH_MUL = 3'd1;
   localparam logic [2:0] ST_HASH_RED = 3'd2;
   localparam logic [2:0] ST_PROBE    = 3'd3;
   localparam logic [2:0] ST_FINISH   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_HASH_MUL;
            end
         end
         ST_HASH_MUL: begin
            cmd.hash_mul = 1'b1;
            state_in     = ST_HASH_RED;
         end
         ST_HASH_RED: begin
            cmd.hash_red = 1'b1;
            state_in     = ST_PROBE;
         end
         ST_PROBE: begin
            cmd.probe = 1'b1;
            if (status.probe_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/prht_datapath.sv
// Datapath: request registers, hash unit, slot store, probe logic and output register.
module prht_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  prht_pkg::ctrl_cmd_type              cmd,
   output prht_pkg::dp_status_type             status,
   input  logic                                req_op,
   input  logic [prht_pkg::KEY_W-1:0]          req_key,
   input  logic [prht_pkg::DATA_W-1:0]         req_data_in,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [prht_pkg::STATUS_W-1:0]       rsp_status,
   output logic [prht_pkg::DATA_W-1:0]         rsp_data_out,
   output logic [prht_pkg::SLOT_F_W-1:0]       rsp_slot,
   output logic [prht_pkg::HASH_F_W-1:0]       rsp_hash_value,
   output logic [prht_pkg::PROBES_W-1:0]       rsp_probes,
   output logic                                rsp_collision
);

   localparam int KW = prht_pkg::KEY_W;
   localparam int SW = prht_pkg::SLOT_W;
   localparam int PW = prht_pkg::PROBE_W;
   localparam int DW = prht_pkg::DATA_W;

   // Request registers.
   logic          op_ff;
   logic [KW-1:0] key_ff;
   logic [DW-1:0] data_ff;

   // Hash unit.
   logic [2*KW-1:0] prod_ff;
   logic [KW-1:0]   quot;
   logic [2*KW-1:0] quot_prime;
   logic [KW-1:0]   rem_raw;
   logic [KW-1:0]   rem_fix;
   logic [SW-1:0]   home_in;
   logic [SW-1:0]   home_ff;

   // Probe state.
   logic [SW-1:0] idx_ff;
   logic          at_home_ff;
   logic [PW-1:0] cnt_ff;

   // Slot store.
   logic [prht_pkg::TOTAL_SLOTS-1:0] valid_ff;
   logic [KW-1:0] entry_key_ff  [prht_pkg::TOTAL_SLOTS];
   logic [DW-1:0] entry_data_ff [prht_pkg::TOTAL_SLOTS];

   // Probe decision.
   logic is_lookup;
   logic slot_valid;
   logic key_eq;
   logic match;
   logic last;
   logic done;

   // Result held until the output register is free.
   logic [prht_pkg::STATUS_W-1:0] res_status_ff;
   logic [DW-1:0]                 res_data_ff;
   logic [SW-1:0]                 res_slot_ff;
   logic [PW-1:0]                 res_probes_ff;
   logic                          res_coll_ff;

   // Output register.
   logic                          rsp_valid_ff;
   logic [prht_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [DW-1:0]                 rsp_data_ff;
   logic [prht_pkg::SLOT_F_W-1:0] rsp_slot_ff;
   logic [prht_pkg::HASH_F_W-1:0] rsp_hash_ff;
   logic [prht_pkg::PROBES_W-1:0] rsp_probes_ff;
   logic                          rsp_coll_ff;
   logic [prht_pkg::PROBES_W-1:0] probes_sat;

   // Remainder: key minus estimated quotient times the prime, then one correction.
   always_comb begin
      quot       = prod_ff[2*KW-1:KW];
      quot_prime = (2*KW)'(quot) * (2*KW)'(prht_pkg::TABLE_PRIME);
      rem_raw    = KW'((2*KW)'(key_ff) - quot_prime);
      if (rem_raw >= KW'(prht_pkg::TABLE_PRIME)) begin
         rem_fix = rem_raw - KW'(prht_pkg::TABLE_PRIME);
      end else begin
         rem_fix = rem_raw;
      end
      home_in = SW'(rem_fix);
   end

   always_comb begin
      is_lookup  = (op_ff == prht_pkg::OP_LOOKUP);
      slot_valid = valid_ff[idx_ff];
      key_eq     = (entry_key_ff[idx_ff] == key_ff);
      match      = is_lookup ? (slot_valid && key_eq) : !slot_valid;
      last       = !at_home_ff && (idx_ff == SW'(prht_pkg::TOTAL_SLOTS - 1));
      done       = match || last;
   end

   assign status.probe_done = done;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (32'(res_probes_ff) > 32'd7) begin
         probes_sat = 3'd7;
      end else begin
         probes_sat = prht_pkg::PROBES_W'(res_probes_ff);
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_op;
         key_ff  <= req_key & prht_pkg::KEY_MASK;
         data_ff <= req_data_in;
      end
      if (cmd.hash_mul) begin
         prod_ff <= (2*KW)'(key_ff) * (2*KW)'(prht_pkg::HASH_RECIP);
      end
      if (cmd.hash_red) begin
         home_ff    <= home_in;
         idx_ff     <= home_in;
         at_home_ff <= 1'b1;
         cnt_ff     <= PW'(1);
      end
      if (cmd.probe) begin
         if (!is_lookup && !slot_valid) begin
            entry_key_ff[idx_ff]  <= key_ff;
            entry_data_ff[idx_ff] <= data_ff;
         end
         if (done) begin
            res_probes_ff <= cnt_ff;
            if (match) begin
               res_status_ff <= is_lookup ? prht_pkg::STATUS_FOUND : prht_pkg::STATUS_INSERTED;
               res_data_ff   <= is_lookup ? entry_data_ff[idx_ff] : '0;
               res_slot_ff   <= idx_ff;
               res_coll_ff   <= !is_lookup && !at_home_ff;
            end else begin
               res_status_ff <= is_lookup ? prht_pkg::STATUS_NOT_FOUND : prht_pkg::STATUS_FULL;
               res_data_ff   <= '0;
               res_slot_ff   <= '0;
               res_coll_ff   <= !is_lookup;
            end
         end else begin
            idx_ff     <= at_home_ff ? SW'(prht_pkg::TABLE_PRIME) : idx_ff + SW'(1);
            at_home_ff <= 1'b0;
            cnt_ff     <= cnt_ff + PW'(1);
         end
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= res_data_ff;
         rsp_slot_ff   <= prht_pkg::SLOT_F_W'(res_slot_ff);
         rsp_hash_ff   <= prht_pkg::HASH_F_W'(home_ff);
         rsp_probes_ff <= probes_sat;
         rsp_coll_ff   <= res_coll_ff;
      end
   end

   // Control registers: valid marks and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.probe && !is_lookup && !slot_valid) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_hash_value = rsp_hash_ff;
   assign rsp_probes     = rsp_probes_ff;
   assign rsp_collision  = rsp_coll_ff;

endmodule

FILE: hw/rtl/prime_remainder_hash_overflow_table.sv
// Top level of the prime remainder hash table with an overflow area.
// A request is hashed in the multiply and reduce states, then probed one slot per cycle, from 1
// to OVERFLOW_SLOTS + 1 slots; the result then waits until the response output is free.
// One transaction at a time passes the single slot compare path; the next request is taken
// once the result has moved to the response register, even while that response waits.
// Reset: synchronous; it clears all valid marks and the response valid, so the
// table is empty and a request can be taken as soon as reset is released.
module prime_remainder_hash_overflow_table (
   input logic        clock,
   input logic        reset,
   prht_req_if.sink   req_bus,
   prht_rsp_if.source rsp_bus
);

   // A miss scans the home slot and every overflow slot; the response saturates the probe count at seven.
   localparam int MISS_PROBES_RAW = prht_pkg::OVERFLOW_SLOTS + 1;
   localparam logic [prht_pkg::PROBES_W-1:0] MISS_PROBES =
      (MISS_PROBES_RAW > 7) ? 3'd7 : prht_pkg::PROBES_W'(MISS_PROBES_RAW);

   prht_pkg::ctrl_cmd_type  cmd;
   prht_pkg::dp_status_type dp_status;

   // The controller only sequences; all storage for the transaction lives in the datapath.
   prht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (dp_status),
      .cmd       (cmd)
   );

   // The datapath owns the slot store, the hash unit and the response register, which
   // lets a finished response wait while the next request is hashed and probed.
   prht_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (dp_status),
      .req_op         (req_bus.op),
      .req_key        (req_bus.key),
      .req_data_in    (req_bus.data_in),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_status     (rsp_bus.status),
      .rsp_data_out   (rsp_bus.data_out),
      .rsp_slot       (rsp_bus.slot),
      .rsp_hash_value (rsp_bus.hash_value),
      .rsp_probes     (rsp_bus.probes),
      .rsp_collision  (rsp_bus.collision)
   );

   // Only one transaction is in flight: acceptance closes the request side.
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while a transaction is in flight");

   // Loading a response always presents it on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_bus.valid)
      else $error("response load did not raise response valid");

   // A lookup miss or a full table has scanned its home slot and every overflow slot and reports no slot.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status == prht_pkg::STATUS_NOT_FOUND ||
                         rsp_bus.status == prht_pkg::STATUS_FULL))
      |-> (rsp_bus.probes == MISS_PROBES && rsp_bus.slot == '0 &&
           rsp_bus.data_out == '0))
      else $error("miss response with wrong probe count or slot");

   // An insert without a collision lands in its home slot after one probe.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == prht_pkg::STATUS_INSERTED && !rsp_bus.collision)
      |-> (rsp_bus.slot == rsp_bus.hash_value && rsp_bus.probes == 3'd1))
      else $error("home insert reported outside its home slot");

endmodule
